// ----- rtl/atbb_pkg.sv -----
`default_nettype none

package atbb_pkg;

  // largest window extent, every sheet coordinate stays below it
  localparam int MAX_DIM = 4096;

  localparam int COORD_W = 12;
  localparam int SIZE_W  = 13;
  localparam int ALPHA_W = 8;
  localparam int CFG_W   = 13;
  localparam int CFG_IDX_W = 3;

  // opcodes of the pixel stream
  localparam logic OP_PIXEL    = 1'b0;
  localparam logic OP_END_CELL = 1'b1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELL_X     = 3'd0,
    REG_CELL_Y     = 3'd1,
    REG_CELL_W     = 3'd2,
    REG_CELL_H     = 3'd3,
    REG_SHEET_W    = 3'd4,
    REG_SHEET_H    = 3'd5,
    REG_OPAQUE_MIN = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic               opcode;
    logic [ALPHA_W-1:0] alpha;
  } pixel_t;

  typedef struct packed {
    logic [COORD_W-1:0] box_x;
    logic [COORD_W-1:0] box_y;
    logic [SIZE_W-1:0]  box_w;
    logic [SIZE_W-1:0]  box_h;
    logic [SIZE_W-1:0]  anchor_x_halves;
    logic [SIZE_W-1:0]  ground_line;
    logic               cell_empty;
  } box_t;

endpackage

`default_nettype wire

// ----- rtl/alpha_trim_bounding_box.sv -----
`default_nettype none

// channel   direction  handshake                 payload
// pix       in         pix_valid / pix_stall     pixel_t  (opcode, alpha)
// box       out        box_valid / box_stall     box_t    (trimmed box, anchor)
// cfg       in         cfg_write                 cfg_index, cfg_data
//
// one pixel transaction per clock while the pixel side is not stalled, set by
// the compare-and-update path from the counters into the min/max registers
// the box of an end-of-cell transaction is offered from the next cycle on
// only an end-of-cell transaction stalls, while a held result fills the
// output register; pixels are taken even then
// rst (synchronous, active high) restores register defaults, clears the box
module alpha_trim_bounding_box
  import atbb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 pix_valid,
  output logic                      pix_stall,
  input  wire pixel_t               pix_data,
  output logic                      box_valid,
  input  wire logic                 box_stall,
  output box_t                      box_data,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  // configuration registers
  logic [COORD_W-1:0] cell_x;
  logic [COORD_W-1:0] cell_y;
  logic [SIZE_W-1:0]  cell_w;
  logic [SIZE_W-1:0]  cell_h;
  logic [SIZE_W-1:0]  sheet_w;
  logic [SIZE_W-1:0]  sheet_h;
  logic [ALPHA_W-1:0] opaque_min;

  // per-cell state: position in the clipped window and running box
  logic [COORD_W-1:0] column_count;
  logic [SIZE_W-1:0]  row_count;
  logic [COORD_W-1:0] min_column;
  logic [COORD_W-1:0] max_column;
  logic [COORD_W-1:0] min_row;
  logic [COORD_W-1:0] max_row;
  logic               any_opaque;

  logic [SIZE_W-1:0]  win_w;
  logic [SIZE_W-1:0]  win_h;
  logic               pix_accept;
  logic               in_window;
  logic               col_in;
  logic               opaque;
  logic               row_wrap;
  logic [COORD_W-1:0] pos_x;
  logic [COORD_W-1:0] pos_y;
  box_t               result;

  // extent of a window edge clipped at the sheet and at MAX_DIM
  function automatic logic [SIZE_W-1:0] clip_span(
    input logic [COORD_W-1:0] start,
    input logic [SIZE_W-1:0]  size,
    input logic [SIZE_W-1:0]  limit
  );
    logic [SIZE_W:0] stop;
    stop = {2'b00, start} + {1'b0, size};
    if (stop > {1'b0, limit}) stop = {1'b0, limit};
    if (stop > (SIZE_W+1)'(MAX_DIM)) stop = (SIZE_W+1)'(MAX_DIM);
    if (stop > {2'b00, start}) begin
      clip_span = SIZE_W'(stop - {2'b00, start});
    end else begin
      clip_span = '0;
    end
  endfunction

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_x     <= '0;
      cell_y     <= '0;
      cell_w     <= SIZE_W'(1);
      cell_h     <= SIZE_W'(1);
      sheet_w    <= SIZE_W'(MAX_DIM);
      sheet_h    <= SIZE_W'(MAX_DIM);
      opaque_min <= ALPHA_W'(16);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CELL_X:     cell_x     <= cfg_data[COORD_W-1:0];
        REG_CELL_Y:     cell_y     <= cfg_data[COORD_W-1:0];
        REG_CELL_W:     cell_w     <= cfg_data[SIZE_W-1:0];
        REG_CELL_H:     cell_h     <= cfg_data[SIZE_W-1:0];
        REG_SHEET_W:    sheet_w    <= cfg_data[SIZE_W-1:0];
        REG_SHEET_H:    sheet_h    <= cfg_data[SIZE_W-1:0];
        REG_OPAQUE_MIN: opaque_min <= cfg_data[ALPHA_W-1:0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // clipped window, recomputed from the registers as they are now
  assign win_w = clip_span(cell_x, cell_w, sheet_w);
  assign win_h = clip_span(cell_y, cell_h, sheet_h);

  // only an end of cell needs the result register
  assign pix_stall  = box_valid && box_stall && (pix_data.opcode == OP_END_CELL);
  assign pix_accept = pix_valid && !pix_stall;

  // pixels past the bottom of the window, or any pixel of an empty window,
  // leave the state alone
  assign in_window = (win_w != '0) && (row_count < win_h);
  // a column count at or past the width (after a width change) is skipped
  assign col_in    = {1'b0, column_count} < win_w;
  assign opaque    = col_in && (pix_data.alpha >= opaque_min);
  assign row_wrap  = ({1'b0, column_count} + SIZE_W'(1)) >= win_w;

  // inside the window both sums stay below MAX_DIM
  assign pos_x = cell_x + column_count;
  assign pos_y = cell_y + row_count[COORD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      min_column   <= '0;
      max_column   <= '0;
      min_row      <= '0;
      max_row      <= '0;
      any_opaque   <= 1'b0;
    end else if (pix_accept) begin
      if (pix_data.opcode == OP_END_CELL) begin
        // next cell starts fresh
        column_count <= '0;
        row_count    <= '0;
        min_column   <= '0;
        max_column   <= '0;
        min_row      <= '0;
        max_row      <= '0;
        any_opaque   <= 1'b0;
      end else if (in_window) begin
        if (opaque) begin
          if (!any_opaque) begin
            min_column <= pos_x;
            max_column <= pos_x;
            min_row    <= pos_y;
            max_row    <= pos_y;
            any_opaque <= 1'b1;
          end else begin
            if (pos_x < min_column) min_column <= pos_x;
            if (pos_x > max_column) max_column <= pos_x;
            if (pos_y < min_row) min_row <= pos_y;
            if (pos_y > max_row) max_row <= pos_y;
          end
        end
        if (row_wrap) begin
          column_count <= '0;
          row_count    <= row_count + SIZE_W'(1);
        end else begin
          column_count <= column_count + COORD_W'(1);
        end
      end
    end
  end

  // trimmed box, or the whole unclipped cell when nothing was opaque
  always_comb begin
    if (any_opaque) begin
      result.box_x = min_column;
      result.box_y = min_row;
      result.box_w = SIZE_W'({1'b0, max_column} - {1'b0, min_column} + SIZE_W'(1));
      result.box_h = SIZE_W'({1'b0, max_row} - {1'b0, min_row} + SIZE_W'(1));
    end else begin
      result.box_x = cell_x;
      result.box_y = cell_y;
      result.box_w = cell_w;
      result.box_h = cell_h;
    end
    // horizontal anchor is the box centre in half pixels
    result.anchor_x_halves = result.box_w;
    result.ground_line     = result.box_h;
    result.cell_empty      = !any_opaque;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      box_valid <= 1'b0;
    end else if (pix_accept && (pix_data.opcode == OP_END_CELL)) begin
      box_valid <= 1'b1;
    end else if (!box_stall) begin
      box_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_accept && (pix_data.opcode == OP_END_CELL)) begin
      box_data <= result;
    end
  end

  // an end of cell leaves a result and a cleared state behind
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    pix_accept && (pix_data.opcode == OP_END_CELL) |=>
      box_valid && !any_opaque && (column_count == '0) && (row_count == '0))
    else $error("end of cell did not clear the state or load a result");

  // before the first opaque pixel the box registers stay cleared
  a_idle_box_zero: assert property (@(posedge clk) disable iff (rst)
    !any_opaque |-> (min_column == '0) && (max_column == '0) &&
                    (min_row == '0) && (max_row == '0))
    else $error("box registers moved without an opaque pixel");

  // running box is never inverted
  a_box_order: assert property (@(posedge clk) disable iff (rst)
    any_opaque |-> (min_column <= max_column) && (min_row <= max_row))
    else $error("running box inverted");

  // a trimmed result has a nonzero size
  a_trim_size: assert property (@(posedge clk) disable iff (rst)
    box_valid && !box_data.cell_empty |-> (box_data.box_w != '0) && (box_data.box_h != '0))
    else $error("trimmed box with zero size");

endmodule

`default_nettype wire

// ----- bench/alpha_trim_bounding_box_tb.sv -----
`timescale 1ns / 1ps

module alpha_trim_bounding_box_tb;
  import atbb_pkg::*;

  localparam int ITEM_GOAL     = 1900;
  localparam int CELL_CAP      = 48;    // pixels per cell in the random part
  localparam int LONG_HOLD     = 300;   // cycles the box side holds off once
  localparam int DRAIN_LIMIT   = 5000;  // cycles to wait for outstanding boxes
  localparam int SETTLE_CYCLES = 4;     // end-of-cell loads its box in the cycle after it is taken
  localparam int PRINT_LIMIT   = 30;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 pix_valid;
  logic                 pix_stall;
  pixel_t               pix_data;
  logic                 box_valid;
  logic                 box_stall = 1'b0;
  box_t                 box_data;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  alpha_trim_bounding_box u_dut (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix_data  (pix_data),
    .box_valid (box_valid),
    .box_stall (box_stall),
    .box_data  (box_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // shadow copy of the block's registers, masked to their widths
  int unsigned cur_cell_x, cur_cell_y, cur_cell_w, cur_cell_h;
  int unsigned cur_sheet_w, cur_sheet_h, cur_threshold;

  // scan position inside the clipped window and the running opaque box
  int unsigned scan_col, scan_row;
  int unsigned box_left, box_right, box_top, box_bottom;
  bit          found_opaque;

  // boxes predicted at end-of-cell, oldest first
  box_t        pending_boxes[$];

  int unsigned items_sent;
  int unsigned mismatches;
  bit          steady;          // both sides run without gaps while set
  int unsigned hold_requests;   // bumped by a test to ask for a long hold-off
  int unsigned holds_served = 0;
  int unsigned hold_left;
  int unsigned wait_left;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // extent of the window along one axis after clipping to the sheet and MAX_DIM
  function automatic int unsigned clipped_extent(input int unsigned start, size, limit);
    int unsigned stop;
    stop = start + size;
    if (stop > limit) stop = limit;
    if (stop > MAX_DIM) stop = MAX_DIM;
    return (stop > start) ? stop - start : 0;
  endfunction

  task automatic clear_scan();
    scan_col = 0;
    scan_row = 0;
    box_left = 0;
    box_right = 0;
    box_top = 0;
    box_bottom = 0;
    found_opaque = 1'b0;
  endtask

  task automatic reset_prediction();
    cur_cell_x = 0;
    cur_cell_y = 0;
    cur_cell_w = 1;
    cur_cell_h = 1;
    cur_sheet_w = MAX_DIM;
    cur_sheet_h = MAX_DIM;
    cur_threshold = 16;
    clear_scan();
  endtask

  // advance the shadow state by one accepted transaction
  task automatic predict_box(input pixel_t px);
    int unsigned win_w, win_h, px_x, px_y, bx, by, bw, bh;
    box_t want;
    win_w = clipped_extent(cur_cell_x, cur_cell_w, cur_sheet_w);
    win_h = clipped_extent(cur_cell_y, cur_cell_h, cur_sheet_h);
    if (px.opcode == OP_PIXEL) begin
      // nothing moves once the window is empty or fully scanned
      if (win_w != 0 && scan_row < win_h) begin
        // a column past a shrunken width is skipped, then wraps
        if (scan_col < win_w && px.alpha >= cur_threshold) begin
          px_x = cur_cell_x + scan_col;
          px_y = cur_cell_y + scan_row;
          if (!found_opaque) begin
            box_left = px_x;
            box_right = px_x;
            box_top = px_y;
            box_bottom = px_y;
            found_opaque = 1'b1;
          end else begin
            if (px_x < box_left) box_left = px_x;
            if (px_x > box_right) box_right = px_x;
            if (px_y < box_top) box_top = px_y;
            if (px_y > box_bottom) box_bottom = px_y;
          end
        end
        if (scan_col + 1 >= win_w) begin
          scan_col = 0;
          scan_row++;
        end else begin
          scan_col++;
        end
      end
    end else begin
      // empty cell falls back to the unclipped cell rectangle
      if (found_opaque) begin
        bx = box_left;
        by = box_top;
        bw = box_right - box_left + 1;
        bh = box_bottom - box_top + 1;
      end else begin
        bx = cur_cell_x;
        by = cur_cell_y;
        bw = cur_cell_w;
        bh = cur_cell_h;
      end
      want.box_x = COORD_W'(bx);
      want.box_y = COORD_W'(by);
      want.box_w = SIZE_W'(bw);
      want.box_h = SIZE_W'(bh);
      want.anchor_x_halves = SIZE_W'(bw);
      want.ground_line = SIZE_W'(bh);
      want.cell_empty = ~found_opaque;
      pending_boxes = {pending_boxes, want};
      clear_scan();
    end
  endtask

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int unsigned got, want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  task automatic check_field(input string name, input int unsigned got, want);
    if (got != want) report_mismatch({"box field ", name}, got, want);
  endtask

  // every box transaction is matched against the oldest predicted box
  always @(posedge clk) begin : check_boxes
    box_t want;
    if (!rst && box_valid && !box_stall) begin
      if (pending_boxes.size() == 0) begin
        report_mismatch("box with no cell closed", box_data.box_x, 0);
      end else begin
        want = pending_boxes.pop_front();
        check_field("box_x", box_data.box_x, want.box_x);
        check_field("box_y", box_data.box_y, want.box_y);
        check_field("box_w", box_data.box_w, want.box_w);
        check_field("box_h", box_data.box_h, want.box_h);
        check_field("anchor_x_halves", box_data.anchor_x_halves, want.anchor_x_halves);
        check_field("ground_line", box_data.ground_line, want.ground_line);
        check_field("cell_empty", box_data.cell_empty, want.cell_empty);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // box side: random stall before each box, plus an occasional long hold-off
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : drive_box_stall
    if (rst) begin
      box_stall <= 1'b0;
      wait_left = 0;
      hold_left = 0;
    end else begin
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left = LONG_HOLD;
      end
      // stall cycles count down only while a box is actually offered
      if (box_valid && !box_stall)
        wait_left = steady ? 0 : $urandom_range(0, 10);
      else if (box_valid && wait_left != 0)
        wait_left--;
      if (hold_left != 0) begin
        hold_left--;
        box_stall <= 1'b1;
      end else begin
        box_stall <= (wait_left != 0);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // pixel side and register writes
  // ---------------------------------------------------------------------------

  // valid stays high from one transaction to the next when no gap is drawn
  task automatic offer_pixel(input logic op, input logic [ALPHA_W-1:0] alpha);
    int unsigned gap;
    pixel_t px;
    px.opcode = op;
    px.alpha = alpha;
    gap = steady ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_valid <= 1'b1;
    pix_data <= px;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
    predict_box(px);
    items_sent++;
  endtask

  // sender stops and waits for every outstanding box, then lets the block settle
  task automatic drain_boxes();
    int unsigned waited;
    pix_valid <= 1'b0;
    waited = 0;
    while (pending_boxes.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_boxes.size() != 0) begin
      report_mismatch("boxes never delivered", pending_boxes.size(), 0);
      pending_boxes.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // only called with the pixel side idle and no box outstanding
  task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(value);
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_CELL_X:     cur_cell_x = value % 4096;
      REG_CELL_Y:     cur_cell_y = value % 4096;
      REG_CELL_W:     cur_cell_w = value % 8192;
      REG_CELL_H:     cur_cell_h = value % 8192;
      REG_SHEET_W:    cur_sheet_w = value % 8192;
      REG_SHEET_H:    cur_sheet_h = value % 8192;
      REG_OPAQUE_MIN: cur_threshold = value % 256;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_window(input int unsigned x, y, w, h, sw, sh, thr);
    write_reg(REG_CELL_X, x);
    write_reg(REG_CELL_Y, y);
    write_reg(REG_CELL_W, w);
    write_reg(REG_CELL_H, h);
    write_reg(REG_SHEET_W, sw);
    write_reg(REG_SHEET_H, sh);
    write_reg(REG_OPAQUE_MIN, thr);
  endtask

  // alpha mix that lands on and around the threshold often
  function automatic logic [ALPHA_W-1:0] pick_alpha();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return ALPHA_W'(cur_threshold);
      3:       return ALPHA_W'(cur_threshold - 1);
      default: return ALPHA_W'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // directed tests
  // ---------------------------------------------------------------------------

  // 1x1 cell at the origin straight out of reset, opaque then empty
  task automatic test_reset_defaults();
    offer_pixel(OP_PIXEL, 8'd255);
    offer_pixel(OP_END_CELL, 8'd0);
    offer_pixel(OP_PIXEL, 8'd15);
    offer_pixel(OP_END_CELL, 8'd255);
    drain_boxes();
  endtask

  // full-size cell clipped to the last 2x2 of the sheet, top threshold,
  // one pixel past the window, then an empty cell reporting the full size
  task automatic test_sheet_corner();
    set_window(4094, 4094, 4096, 4096, 4096, 4096, 255);
    offer_pixel(OP_PIXEL, 8'd255);
    offer_pixel(OP_PIXEL, 8'd254);
    offer_pixel(OP_PIXEL, 8'd0);
    offer_pixel(OP_PIXEL, 8'd255);
    offer_pixel(OP_PIXEL, 8'd255);
    offer_pixel(OP_END_CELL, 8'd0);
    offer_pixel(OP_END_CELL, 8'd0);
    drain_boxes();
  endtask

  // sheet larger than MAX_DIM: window clipped to a single pixel, zero threshold
  task automatic test_oversized_sheet();
    set_window(4095, 4095, 8191, 8191, 8191, 8191, 0);
    offer_pixel(OP_PIXEL, 8'd0);
    offer_pixel(OP_PIXEL, 8'd0);
    offer_pixel(OP_END_CELL, 8'd0);
    drain_boxes();
  endtask

  // cell starts right of the sheet edge, every pixel ignored
  task automatic test_outside_sheet();
    set_window(100, 5, 4, 4, 100, 4096, 16);
    offer_pixel(OP_PIXEL, 8'd255);
    offer_pixel(OP_PIXEL, 8'd255);
    offer_pixel(OP_END_CELL, 8'd0);
    drain_boxes();
  endtask

  // zero width and height, empty result carries the zero size
  task automatic test_zero_size();
    set_window(7, 9, 0, 0, 4096, 4096, 16);
    offer_pixel(OP_PIXEL, 8'd255);
    offer_pixel(OP_END_CELL, 8'd0);
    drain_boxes();
  endtask

  // width shrinks under a column count already at the new width: that
  // pixel is skipped and the scan wraps to the next row
  task automatic test_window_change_mid_cell();
    set_window(10, 20, 3, 2, 4096, 4096, 16);
    offer_pixel(OP_PIXEL, 8'd255);
    offer_pixel(OP_PIXEL, 8'd0);
    drain_boxes();
    write_reg(REG_CELL_W, 2);
    offer_pixel(OP_PIXEL, 8'd255);
    offer_pixel(OP_PIXEL, 8'd255);
    offer_pixel(OP_END_CELL, 8'd0);
    drain_boxes();
  endtask

  // box side holds off while short cells keep coming, so the result register
  // fills and the next end-of-cell stalls the pixel side
  task automatic test_backpressure();
    set_window(0, 0, 2, 1, 4096, 4096, 16);
    steady = 1'b1;
    hold_requests++;
    repeat (12) begin
      offer_pixel(OP_PIXEL, pick_alpha());
      offer_pixel(OP_PIXEL, pick_alpha());
      offer_pixel(OP_END_CELL, ALPHA_W'($urandom));
    end
    drain_boxes();
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // random cells
  // ---------------------------------------------------------------------------

  task automatic randomize_window();
    int unsigned sw, sh, x, y, w, h, thr;
    sw = $urandom_range(0, 1) ? MAX_DIM : $urandom_range(1, MAX_DIM);
    sh = $urandom_range(0, 1) ? MAX_DIM : $urandom_range(1, MAX_DIM);
    x = $urandom_range(0, sw - 1);
    y = $urandom_range(0, sh - 1);
    w = $urandom_range(1, 8);
    h = $urandom_range(1, 6);
    case ($urandom_range(0, 9))
      6: begin
        // hugging the right and bottom edges, oversized cell clipped
        x = sw - $urandom_range(1, (sw > 3) ? 3 : sw);
        y = sh - $urandom_range(1, (sh > 3) ? 3 : sh);
        w = $urandom_range(4, 8191);
        h = $urandom_range(4, 8191);
      end
      7: begin
        // window starts off the sheet
        sw = $urandom_range(1, MAX_DIM - 1);
        x = $urandom_range(sw, MAX_DIM - 1);
      end
      8: begin
        if ($urandom_range(0, 1)) w = 0;
        else h = 0;
      end
      9: begin
        // raw 13-bit writes, high bits masked by the narrower registers
        x = $urandom_range(0, 8191);
        y = $urandom_range(0, 8191);
        w = $urandom_range(0, 8191);
        h = $urandom_range(0, 8191);
        sw = $urandom_range(0, 8191);
        sh = $urandom_range(0, 8191);
      end
      default: ;
    endcase
    case ($urandom_range(0, 3))
      0:       thr = 0;
      1:       thr = 255;
      default: thr = $urandom_range(0, 255);
    endcase
    set_window(x, y, w, h, sw, sh, thr);
  endtask

  // one register changed partway through a cell
  task automatic nudge_register();
    cfg_reg_t idx;
    int unsigned value;
    idx = cfg_reg_t'($urandom_range(0, 6));
    case (idx) inside
      REG_CELL_W, REG_CELL_H: value = $urandom_range(0, 8);
      REG_OPAQUE_MIN:         value = $urandom_range(0, 255);
      default:                value = $urandom_range(0, MAX_DIM);
    endcase
    write_reg(idx, value);
  endtask

  // mostly complete cells with random alpha; some overrun, cut short or
  // have a register changed in the middle
  task automatic test_random_cells();
    int unsigned area, budget, shape, split;
    while (items_sent < ITEM_GOAL) begin
      drain_boxes();
      randomize_window();
      steady = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(3, 12)) begin
        area = clipped_extent(cur_cell_x, cur_cell_w, cur_sheet_w) *
               clipped_extent(cur_cell_y, cur_cell_h, cur_sheet_h);
        shape = $urandom_range(0, 9);
        budget = (area > CELL_CAP) ? $urandom_range(1, CELL_CAP) : area;
        if (shape == 7)
          budget = budget + $urandom_range(1, 4);
        else if (shape == 8 && budget != 0)
          budget = $urandom_range(0, budget - 1);
        if (shape == 9) begin
          split = $urandom_range(0, budget);
          repeat (split) offer_pixel(OP_PIXEL, pick_alpha());
          drain_boxes();
          nudge_register();
          budget = budget - split + $urandom_range(0, 3);
        end
        repeat (budget) offer_pixel(OP_PIXEL, pick_alpha());
        offer_pixel(OP_END_CELL, ALPHA_W'($urandom));
      end
    end
    steady = 1'b0;
    drain_boxes();
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst = 1'b1;
    pix_valid = 1'b0;
    pix_data = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    items_sent = 0;
    mismatches = 0;
    steady = 1'b0;
    hold_requests = 0;
    reset_prediction();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_sheet_corner();
    test_oversized_sheet();
    test_outside_sheet();
    test_zero_size();
    test_window_change_mid_cell();
    test_backpressure();
    test_random_cells();

    if (mismatches == 0) begin
      $display("alpha_trim_bounding_box: match");
    end else begin
      $display("alpha_trim_bounding_box: mismatch");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("alpha_trim_bounding_box: mismatch");
    $finish;
  end

endmodule
